// ===== design/rse_pkg.sv =====
// Shared types, codes and constants of the postfix expression evaluator.
package rse_pkg;

   localparam int DATA_W          = 32;
   localparam int WIDE_W          = 64;
   localparam int STACK_DEPTH_DEF = 32;
   localparam int FRAC_BITS_DEF   = 16;

   // token codes (code 7 is unused and treated as a bad character)
   typedef enum logic [2:0] {
      CMD_PUSH = 3'd0,
      CMD_ADD  = 3'd1,
      CMD_SUB  = 3'd2,
      CMD_MUL  = 3'd3,
      CMD_DIV  = 3'd4,
      CMD_END  = 3'd5,
      CMD_BAD  = 3'd6
   } cmd_type;

   // result kinds
   typedef enum logic [1:0] {
      KIND_NONE    = 2'd0,
      KIND_INTER   = 2'd1,
      KIND_FINAL   = 2'd2,
      KIND_INVALID = 2'd3
   } kind_type;

   // error codes
   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_UNDERFLOW = 3'd1,
      ERR_DIVZERO   = 3'd2,
      ERR_BADCHAR   = 3'd3,
      ERR_EMPTY     = 3'd4,
      ERR_LEFTOVER  = 3'd5,
      ERR_OVERFLOW  = 3'd6
   } err_type;

   // sequencer to arithmetic unit
   typedef struct packed {
      logic    start;
      cmd_type op;
   } alu_req_type;

   // arithmetic unit to sequencer
   typedef struct packed {
      logic              done;
      logic [DATA_W-1:0] result;
   } alu_rsp_type;

endpackage

// ===== design/rse_stack.sv =====
// Operand stack memory: one write port, one registered read port.
module rse_stack #(
   parameter int STACK_DEPTH = rse_pkg::STACK_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [$clog2(STACK_DEPTH)-1:0] wr_addr,
   input  logic [rse_pkg::DATA_W-1:0]     wr_data,
   input  logic [$clog2(STACK_DEPTH)-1:0] rd_addr,
   output logic [rse_pkg::DATA_W-1:0]     rd_data
);
   import rse_pkg::*;

   logic [DATA_W-1:0] mem_ff [STACK_DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/rse_alu.sv =====
// Shared iterative arithmetic unit: add, subtract, multiply, divide with saturation.
module rse_alu #(
   parameter int FRAC_BITS = rse_pkg::FRAC_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  rse_pkg::alu_req_type       alu_req,
   input  logic [rse_pkg::DATA_W-1:0] left,
   input  logic [rse_pkg::DATA_W-1:0] right,
   output rse_pkg::alu_rsp_type       alu_rsp
);
   import rse_pkg::*;

   // quotient width: |left| shifted up by the fraction bits
   localparam int QW = DATA_W + FRAC_BITS;
   localparam int CW = $clog2(QW);
   localparam logic [CW-1:0] LAST_STEP = CW'(QW - 1);
   localparam logic signed [WIDE_W-1:0] BIAS =
      (WIDE_W'(1) << FRAC_BITS) - WIDE_W'(1);

   typedef enum logic [2:0] {
      A_IDLE,
      A_ADD,
      A_MUL,
      A_SHIFT,
      A_DIV,
      A_SIGN,
      A_SAT
   } alu_state_type;

   alu_state_type             state_ff;
   cmd_type                   op_ff;
   logic signed [DATA_W-1:0]  l_ff;
   logic signed [DATA_W-1:0]  r_ff;
   logic signed [WIDE_W-1:0]  wide_ff;
   logic [QW-1:0]             quo_ff;
   logic [DATA_W-1:0]         rem_ff;
   logic [DATA_W-1:0]         dvs_ff;
   logic [CW-1:0]             cnt_ff;
   logic                      neg_ff;
   logic [DATA_W-1:0]         result_ff;
   logic                      done_ff;

   logic [DATA_W-1:0]         mag_l;
   logic [DATA_W-1:0]         mag_r;
   logic [DATA_W:0]           trial;
   logic [DATA_W:0]           diff;
   logic                      fits;
   logic signed [WIDE_W-1:0]  biased;
   logic signed [WIDE_W-1:0]  shifted;
   logic [WIDE_W-1:0]         quo_wide;
   logic                      over_pos;
   logic                      over_neg;
   logic [DATA_W-1:0]         sat_val;

   // operand magnitudes for the divider
   assign mag_l = left[DATA_W-1]  ? (~left + DATA_W'(1))  : left;
   assign mag_r = right[DATA_W-1] ? (~right + DATA_W'(1)) : right;

   // one restoring divide step
   assign trial = {rem_ff, quo_ff[QW-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = (trial >= {1'b0, dvs_ff});

   // product scaling, truncated toward zero
   assign biased  = wide_ff + (wide_ff[WIDE_W-1] ? BIAS : '0);
   assign shifted = biased >>> FRAC_BITS;

   assign quo_wide = {{(WIDE_W-QW){1'b0}}, quo_ff};

   // saturate the wide result to 32 bits
   assign over_pos = !wide_ff[WIDE_W-1] && (wide_ff[WIDE_W-2:DATA_W-1] != '0);
   assign over_neg =  wide_ff[WIDE_W-1] && (wide_ff[WIDE_W-2:DATA_W-1] != '1);

   always_comb begin
      priority if (over_pos) begin
         sat_val = {1'b0, {(DATA_W-1){1'b1}}};
      end else if (over_neg) begin
         sat_val = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         sat_val = wide_ff[DATA_W-1:0];
      end
   end

   // sequencer of the unit
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
         done_ff  <= 1'b0;
      end else begin
         // done pulses for one cycle after the saturation step
         done_ff <= (state_ff == A_SAT);
         unique case (state_ff)
            A_IDLE: begin
               if (alu_req.start) begin
                  op_ff  <= alu_req.op;
                  l_ff   <= left;
                  r_ff   <= right;
                  quo_ff <= {mag_l, {FRAC_BITS{1'b0}}};
                  rem_ff <= '0;
                  dvs_ff <= mag_r;
                  cnt_ff <= '0;
                  neg_ff <= left[DATA_W-1] ^ right[DATA_W-1];
                  unique case (alu_req.op)
                     CMD_ADD, CMD_SUB: state_ff <= A_ADD;
                     CMD_MUL:          state_ff <= A_MUL;
                     CMD_DIV:          state_ff <= A_DIV;
                     default:          state_ff <= A_IDLE;
                  endcase
               end
            end
            A_ADD: begin
               if (op_ff == CMD_SUB) begin
                  wide_ff <= {{DATA_W{l_ff[DATA_W-1]}}, l_ff}
                           - {{DATA_W{r_ff[DATA_W-1]}}, r_ff};
               end else begin
                  wide_ff <= {{DATA_W{l_ff[DATA_W-1]}}, l_ff}
                           + {{DATA_W{r_ff[DATA_W-1]}}, r_ff};
               end
               state_ff <= A_SAT;
            end
            A_MUL: begin
               wide_ff  <= l_ff * r_ff;
               state_ff <= A_SHIFT;
            end
            A_SHIFT: begin
               wide_ff  <= shifted;
               state_ff <= A_SAT;
            end
            A_DIV: begin
               rem_ff <= fits ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
               quo_ff <= {quo_ff[QW-2:0], fits};
               cnt_ff <= cnt_ff + CW'(1);
               if (cnt_ff == LAST_STEP) begin
                  state_ff <= A_SIGN;
               end
            end
            A_SIGN: begin
               wide_ff  <= neg_ff ? (~quo_wide + WIDE_W'(1)) : quo_wide;
               state_ff <= A_SAT;
            end
            A_SAT: begin
               result_ff <= sat_val;
               state_ff  <= A_IDLE;
            end
            default: state_ff <= A_IDLE;
         endcase
      end
   end

   assign alu_rsp.done   = done_ff;
   assign alu_rsp.result = result_ff;

endmodule

// ===== design/rpn_stack_evaluator_top.sv =====
// Top level of the postfix expression evaluator: token sequencer, stack and arithmetic unit.
//
//   channel | dir | tdata                          | tuser
//   req_    | in  | [31:0] operand                 | [2:0] cmd
//   rsp_    | out | [31:0] value, [34:32] err code | [1:0] kind
//
// One token at a time; req_tready is high only while the sequencer is idle.
// Push, end, bad and underflowing tokens skip the arithmetic unit; a zero
// divisor is found once the right operand is read, before the unit starts.
// Add, subtract, multiply and divide run in the shared arithmetic unit, which
// divides at one quotient bit per cycle.
// A finished result waits in the output register; the next token is accepted
// meanwhile and stalls only when its own result finds that register full.
// Reset is synchronous and empties the stack and the error latch.
module rpn_stack_evaluator_top #(
   parameter int STACK_DEPTH = rse_pkg::STACK_DEPTH_DEF,
   parameter int FRAC_BITS   = rse_pkg::FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] operand
   input  logic [2:0]  req_tuser,   // [2:0] cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] value, [34:32] error_code, [39:35] zero
   output logic [1:0]  rsp_tuser    // [1:0] kind
);
   import rse_pkg::*;

   localparam int AW   = $clog2(STACK_DEPTH);
   localparam int CNTW = $clog2(STACK_DEPTH + 1);
   localparam logic [CNTW-1:0] DEPTH_CNT = CNTW'(STACK_DEPTH);

   typedef enum logic [2:0] {
      S_IDLE,
      S_RIGHT,
      S_LEFT,
      S_ALU,
      S_FINAL,
      S_EMIT
   } seq_state_type;

   seq_state_type     state_ff;
   cmd_type           cmd_ff;
   logic [CNTW-1:0]   count_ff;
   logic              err_seen_ff;
   err_type           first_err_ff;
   logic [DATA_W-1:0] right_ff;
   kind_type          pend_kind_ff;
   logic [DATA_W-1:0] pend_value_ff;
   err_type           pend_err_ff;
   logic              rsp_valid_ff;
   kind_type          rsp_kind_ff;
   logic [DATA_W-1:0] rsp_value_ff;
   err_type           rsp_err_ff;

   cmd_type           cmd_in;
   logic              req_fire;
   logic [AW-1:0]     top_idx;
   logic              stk_wr_en;
   logic [AW-1:0]     stk_wr_addr;
   logic [DATA_W-1:0] stk_wr_data;
   logic [AW-1:0]     stk_rd_addr;
   logic [DATA_W-1:0] stk_rd_data;
   logic              div_zero;
   alu_req_type       alu_req;
   alu_rsp_type       alu_rsp;

   assign cmd_in     = cmd_type'(req_tuser);
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign top_idx    = count_ff[AW-1:0] - AW'(1);
   assign div_zero   = (cmd_ff == CMD_DIV) && (right_ff == '0);

   // stack read address: top first, then the one below; entry 0 for end
   always_comb begin
      unique case (state_ff)
         S_IDLE:  stk_rd_addr = (cmd_in == CMD_END) ? '0 : top_idx;
         S_RIGHT: stk_rd_addr = top_idx - AW'(1);
         default: stk_rd_addr = '0;
      endcase
   end

   // stack writes: pushes and operator results
   always_comb begin
      stk_wr_en   = 1'b0;
      stk_wr_addr = count_ff[AW-1:0];
      stk_wr_data = req_tdata;
      if (req_fire && (cmd_in == CMD_PUSH) && !err_seen_ff && (count_ff < DEPTH_CNT)) begin
         stk_wr_en = 1'b1;
      end else if ((state_ff == S_ALU) && alu_rsp.done) begin
         stk_wr_en   = 1'b1;
         stk_wr_addr = top_idx - AW'(1);
         stk_wr_data = alu_rsp.result;
      end
   end

   // start the arithmetic unit once both operands are read
   assign alu_req.start = (state_ff == S_LEFT) && !div_zero;
   assign alu_req.op    = cmd_ff;

   rse_stack #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (stk_wr_en),
      .wr_addr (stk_wr_addr),
      .wr_data (stk_wr_data),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_rd_data)
   );

   rse_alu #(
      .FRAC_BITS (FRAC_BITS)
   ) u_alu (
      .clock   (clock),
      .reset   (reset),
      .alu_req (alu_req),
      .left    (stk_rd_data),
      .right   (right_ff),
      .alu_rsp (alu_rsp)
   );

   // token sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         err_seen_ff  <= 1'b0;
         first_err_ff <= ERR_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // taken item leaves; S_EMIT refills the register itself
         if (rsp_valid_ff && rsp_tready && (state_ff != S_EMIT)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  cmd_ff        <= cmd_in;
                  pend_value_ff <= '0;
                  if (cmd_in == CMD_END) begin
                     count_ff     <= '0;
                     err_seen_ff  <= 1'b0;
                     first_err_ff <= ERR_NONE;
                     priority if (err_seen_ff) begin
                        pend_kind_ff <= KIND_INVALID;
                        pend_err_ff  <= first_err_ff;
                        state_ff     <= S_EMIT;
                     end else if (count_ff == '0) begin
                        pend_kind_ff <= KIND_INVALID;
                        pend_err_ff  <= ERR_EMPTY;
                        state_ff     <= S_EMIT;
                     end else if (count_ff > CNTW'(1)) begin
                        pend_kind_ff <= KIND_INVALID;
                        pend_err_ff  <= ERR_LEFTOVER;
                        state_ff     <= S_EMIT;
                     end else begin
                        pend_kind_ff <= KIND_NONE;
                        pend_err_ff  <= ERR_NONE;
                        state_ff     <= S_FINAL;
                     end
                  end else begin
                     pend_kind_ff <= KIND_NONE;
                     pend_err_ff  <= ERR_NONE;
                     if (err_seen_ff) begin
                        state_ff <= S_EMIT;
                     end else begin
                        unique case (cmd_in)
                           CMD_PUSH: begin
                              state_ff <= S_EMIT;
                              if (count_ff >= DEPTH_CNT) begin
                                 err_seen_ff  <= 1'b1;
                                 first_err_ff <= ERR_OVERFLOW;
                              end else begin
                                 count_ff <= count_ff + CNTW'(1);
                              end
                           end
                           CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
                              if (count_ff < CNTW'(2)) begin
                                 err_seen_ff  <= 1'b1;
                                 first_err_ff <= ERR_UNDERFLOW;
                                 state_ff     <= S_EMIT;
                              end else begin
                                 state_ff <= S_RIGHT;
                              end
                           end
                           default: begin
                              err_seen_ff  <= 1'b1;
                              first_err_ff <= ERR_BADCHAR;
                              state_ff     <= S_EMIT;
                           end
                        endcase
                     end
                  end
               end
            end
            S_RIGHT: begin
               right_ff <= stk_rd_data;
               state_ff <= S_LEFT;
            end
            S_LEFT: begin
               if (div_zero) begin
                  err_seen_ff  <= 1'b1;
                  first_err_ff <= ERR_DIVZERO;
                  state_ff     <= S_EMIT;
               end else begin
                  state_ff <= S_ALU;
               end
            end
            S_ALU: begin
               if (alu_rsp.done) begin
                  count_ff      <= count_ff - CNTW'(1);
                  pend_kind_ff  <= KIND_INTER;
                  pend_value_ff <= alu_rsp.result;
                  state_ff      <= S_EMIT;
               end
            end
            S_FINAL: begin
               pend_kind_ff  <= KIND_FINAL;
               pend_value_ff <= stk_rd_data;
               state_ff      <= S_EMIT;
            end
            S_EMIT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_kind_ff  <= pend_kind_ff;
                  rsp_value_ff <= pend_value_ff;
                  rsp_err_ff   <= pend_err_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_err_ff, rsp_value_ff};
   assign rsp_tuser  = rsp_kind_ff;

`ifndef SYNTH
   // stack fill never exceeds its depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("stack count beyond depth");

   // an end token leaves an empty stack and a clear error latch
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (cmd_in == CMD_END)) |=> ((count_ff == '0) && !err_seen_ff))
      else $error("end token did not clear the stack");

   // an error code goes out with an invalid result and only then
   a_err_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_kind_ff == KIND_INVALID) == (rsp_err_ff != ERR_NONE)))
      else $error("error code and result kind disagree");

   // results without a value carry zero
   a_zero_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && ((rsp_kind_ff == KIND_NONE) || (rsp_kind_ff == KIND_INVALID)))
      |-> (rsp_value_ff == '0))
      else $error("nonzero value on a result without one");
`endif

endmodule
